// ----- hw/rtl/blsp_pkg.sv -----
// types, codes and constants shared by the segment parser modules
`default_nettype none

package blsp_pkg;

  // byte offset width and segment number limit
  localparam int unsigned OFFSET_BITS  = 24;
  localparam logic [7:0]  MAX_SEGMENTS = 8'd255;

  // header marker byte and header lengths
  localparam logic [7:0] MARKER_BYTE  = 8'hFF;
  localparam logic [2:0] HDR_LEN_MARK = 3'd6;
  localparam logic [2:0] HDR_LEN_BARE = 3'd4;

  // parse phases
  typedef enum logic [2:0] {
    PH_HEAD0 = 3'd0,
    PH_HEAD1 = 3'd1,
    PH_STLO  = 3'd2,
    PH_STHI  = 3'd3,
    PH_ENDLO = 3'd4,
    PH_ENDHI = 3'd5,
    PH_DATA  = 3'd6
  } phase_e;

  // error codes
  typedef enum logic [1:0] {
    ERR_NONE  = 2'd0,
    ERR_ORDER = 2'd1,
    ERR_TRUNC = 2'd2,
    ERR_COUNT = 2'd3
  } err_e;

  // one input item
  typedef struct packed {
    logic [7:0] stream_byte;
    logic       final_byte;
  } in_item_t;

  // item handed to the parser, fire marks the cycle it is consumed
  typedef struct packed {
    logic     fire;
    in_item_t item;
  } step_t;

  // segment descriptor
  typedef struct packed {
    logic [7:0]             segment_index;
    logic [OFFSET_BITS-1:0] header_offset;
    logic [15:0]            load_start;
    logic [15:0]            load_end;
    logic [16:0]            total_length;
    logic                   marker_seen;
    err_e                   error_code;
  } seg_desc_t;

  // descriptor with its valid bit
  typedef struct packed {
    logic      valid;
    seg_desc_t desc;
  } seg_res_t;

endpackage

`default_nettype wire

// ----- hw/rtl/binary_load_segment_parser_core.sv -----
// Segment parser for a segmented binary load image. Bytes enter one per
// transfer with a flag on the last byte; each completed segment header gives
// one descriptor (number, header offset, start, end, total length, marker)
// and errors give one flagged descriptor, after which all bytes are dropped
// until reset. The block takes one byte per clock cycle unless a held result
// stalls it: a byte goes from the input register through the parse step into
// the result register, where its descriptor is registered. A held result
// stalls the input only once the input register also holds a byte.
// Throughput is set only by the handshakes on the two channels.
`default_nettype none

module binary_load_segment_parser_core (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              in_valid_i,
  output logic                                   in_ready_o,
  input  wire logic [7:0]                        stream_byte_i,
  input  wire logic                              final_byte_i,
  output logic                                   out_valid_o,
  input  wire logic                              out_ready_i,
  output logic [7:0]                             segment_index_o,
  output logic [blsp_pkg::OFFSET_BITS-1:0]       header_offset_o,
  output logic [15:0]                            load_start_o,
  output logic [15:0]                            load_end_o,
  output logic [16:0]                            total_length_o,
  output logic                                   marker_seen_o,
  output logic [1:0]                             error_code_o
);
  import blsp_pkg::*;

  step_t     step;
  seg_res_t  res;
  seg_desc_t desc;
  logic      advance;

  // input register
  blsp_in_reg u_in_reg (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .stream_byte_i (stream_byte_i),
    .final_byte_i  (final_byte_i),
    .advance_i     (advance),
    .step_o        (step)
  );

  // parse state and step
  blsp_parser u_parser (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (step),
    .res_o  (res)
  );

  // result register
  blsp_out_reg u_out_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .res_i       (res),
    .fire_i      (step.fire),
    .out_ready_i (out_ready_i),
    .advance_o   (advance),
    .out_valid_o (out_valid_o),
    .desc_o      (desc)
  );

  assign segment_index_o = desc.segment_index;
  assign header_offset_o = desc.header_offset;
  assign load_start_o    = desc.load_start;
  assign load_end_o      = desc.load_end;
  assign total_length_o  = desc.total_length;
  assign marker_seen_o   = desc.marker_seen;
  assign error_code_o    = desc.error_code;

endmodule

`default_nettype wire

// ----- hw/rtl/blsp_in_reg.sv -----
// input register stage of the segment parser
`default_nettype none

module blsp_in_reg (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           in_valid_i,
  output logic                in_ready_o,
  input  wire logic [7:0]     stream_byte_i,
  input  wire logic           final_byte_i,
  input  wire logic           advance_i,
  output blsp_pkg::step_t     step_o
);
  import blsp_pkg::*;

  logic     valid_q, valid_d;
  in_item_t item_q;

  // free when empty or when the held byte moves on this cycle
  assign in_ready_o = !valid_q || advance_i;

  always_comb begin
    valid_d = valid_q;
    if (in_ready_o) begin
      valid_d = in_valid_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // payload capture on each input transfer
  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      item_q.stream_byte <= stream_byte_i;
      item_q.final_byte  <= final_byte_i;
    end
  end

  assign step_o.fire = valid_q && advance_i;
  assign step_o.item = item_q;

endmodule

`default_nettype wire

// ----- hw/rtl/blsp_parser.sv -----
// parse state and one-byte step logic of the segment parser
`default_nettype none

module blsp_parser (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire blsp_pkg::step_t  step_i,
  output blsp_pkg::seg_res_t    res_o
);
  import blsp_pkg::*;

  phase_e                 phase_q, phase_d;
  logic [OFFSET_BITS-1:0] offset_q, offset_d;
  logic [OFFSET_BITS-1:0] head_q, head_d;
  logic [7:0]             low_q, low_d;
  logic [15:0]            start_q, start_d;
  logic [7:0]             endlo_q, endlo_d;
  logic [16:0]            remain_q, remain_d;
  logic [7:0]             count_q, count_d;
  logic                   marker_q, marker_d;
  logic                   halted_q, halted_d;

  logic [7:0]  b;
  logic        fin;
  logic        hdr_step;
  logic [15:0] end_val;
  logic [7:0]  count_inc;
  logic [16:0] remain_dec;
  logic [16:0] seg_len;

  assign b         = step_i.item.stream_byte;
  assign fin       = step_i.item.final_byte;
  assign end_val   = {b, endlo_q};
  assign count_inc = count_q + 8'd1;
  assign remain_dec = remain_q - 17'd1;
  assign seg_len   = {1'b0, end_val} - {1'b0, start_q} + 17'd1;

  // next state and descriptor for the byte at the head of the input register
  always_comb begin
    phase_d  = phase_q;
    offset_d = offset_q;
    head_d   = head_q;
    low_d    = low_q;
    start_d  = start_q;
    endlo_d  = endlo_q;
    remain_d = remain_q;
    count_d  = count_q;
    marker_d = marker_q;
    halted_d = halted_q;
    hdr_step = 1'b0;
    res_o    = '0;

    if (step_i.fire && !halted_q) begin
      offset_d = offset_q + OFFSET_BITS'(1);
      case (phase_q)
        PH_HEAD0: begin
          if (count_q >= MAX_SEGMENTS) begin
            // out of segment numbers
            res_o.valid              = 1'b1;
            res_o.desc.segment_index = count_q;
            res_o.desc.header_offset = offset_q;
            res_o.desc.error_code    = ERR_COUNT;
            halted_d                 = 1'b1;
          end else begin
            head_d   = offset_q;
            low_d    = b;
            marker_d = 1'b0;
            start_d  = '0;
            phase_d  = PH_HEAD1;
            hdr_step = 1'b1;
          end
        end
        PH_HEAD1: begin
          if (low_q == MARKER_BYTE && b == MARKER_BYTE) begin
            marker_d = 1'b1;
            phase_d  = PH_STLO;
          end else begin
            start_d = {b, low_q};
            phase_d = PH_ENDLO;
          end
          hdr_step = 1'b1;
        end
        PH_STLO: begin
          low_d    = b;
          phase_d  = PH_STHI;
          hdr_step = 1'b1;
        end
        PH_STHI: begin
          start_d  = {b, low_q};
          phase_d  = PH_ENDLO;
          hdr_step = 1'b1;
        end
        PH_ENDLO: begin
          endlo_d  = b;
          phase_d  = PH_ENDHI;
          hdr_step = 1'b1;
        end
        PH_ENDHI: begin
          // header complete: descriptor goes out
          count_d                  = count_inc;
          res_o.valid              = 1'b1;
          res_o.desc.segment_index = count_inc;
          res_o.desc.header_offset = head_q;
          res_o.desc.load_start    = start_q;
          res_o.desc.load_end      = end_val;
          res_o.desc.marker_seen   = marker_q;
          if (end_val < start_q) begin
            res_o.desc.error_code = ERR_ORDER;
            halted_d              = 1'b1;
          end else begin
            remain_d                = seg_len;
            res_o.desc.total_length = seg_len +
                                      {14'd0, (marker_q ? HDR_LEN_MARK : HDR_LEN_BARE)};
            res_o.desc.error_code   = fin ? ERR_TRUNC : ERR_NONE;
            phase_d                 = PH_DATA;
            halted_d                = fin;
          end
        end
        default: begin
          // data phase: count down the segment body
          if (remain_q != '0) begin
            remain_d = remain_dec;
          end
          if (remain_q == '0 || remain_dec == '0) begin
            phase_d  = PH_HEAD0;
            halted_d = fin;
          end else if (fin) begin
            res_o.valid              = 1'b1;
            res_o.desc.segment_index = count_q;
            res_o.desc.header_offset = head_q;
            res_o.desc.load_start    = start_q;
            res_o.desc.marker_seen   = marker_q;
            res_o.desc.error_code    = ERR_TRUNC;
            halted_d                 = 1'b1;
          end
        end
      endcase

      // stream ends inside a header
      if (hdr_step && fin) begin
        res_o.valid              = 1'b1;
        res_o.desc.segment_index = count_inc;
        res_o.desc.header_offset = head_d;
        res_o.desc.load_start    = start_d;
        res_o.desc.marker_seen   = marker_d;
        res_o.desc.error_code    = ERR_TRUNC;
        halted_d                 = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_HEAD0;
      offset_q <= '0;
      head_q   <= '0;
      low_q    <= '0;
      start_q  <= '0;
      endlo_q  <= '0;
      remain_q <= '0;
      count_q  <= '0;
      marker_q <= 1'b0;
      halted_q <= 1'b0;
    end else begin
      phase_q  <= phase_d;
      offset_q <= offset_d;
      head_q   <= head_d;
      low_q    <= low_d;
      start_q  <= start_d;
      endlo_q  <= endlo_d;
      remain_q <= remain_d;
      count_q  <= count_d;
      marker_q <= marker_d;
      halted_q <= halted_d;
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/blsp_out_reg.sv -----
// result register stage of the segment parser
`default_nettype none

module blsp_out_reg (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire blsp_pkg::seg_res_t res_i,
  input  wire logic               fire_i,
  input  wire logic               out_ready_i,
  output logic                    advance_o,
  output logic                    out_valid_o,
  output blsp_pkg::seg_desc_t     desc_o
);
  import blsp_pkg::*;

  logic      valid_q, valid_d;
  seg_desc_t desc_q;

  // the parser may step when the result slot is empty or being taken
  assign advance_o = !valid_q || out_ready_i;

  always_comb begin
    valid_d = valid_q;
    if (fire_i) begin
      valid_d = res_i.valid;
    end else if (out_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // descriptor capture
  always_ff @(posedge clk_i) begin
    if (fire_i && res_i.valid) begin
      desc_q <= res_i.desc;
    end
  end

  assign out_valid_o = valid_q;
  assign desc_o      = desc_q;

endmodule

`default_nettype wire

// ----- hw/rtl/blsp_checker.sv -----
// port checker for the segment parser and its bind
`default_nettype none

module blsp_checker (
  input wire logic                        clk_i,
  input wire logic                        rst_ni,
  input wire logic                        out_valid_o,
  input wire logic                        out_ready_i,
  input wire logic [7:0]                  segment_index_o,
  input wire logic [blsp_pkg::OFFSET_BITS-1:0] header_offset_o,
  input wire logic [15:0]                 load_start_o,
  input wire logic [15:0]                 load_end_o,
  input wire logic [16:0]                 total_length_o,
  input wire logic                        marker_seen_o,
  input wire logic [1:0]                  error_code_o
);
  import blsp_pkg::*;

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(segment_index_o) &&
      $stable(header_offset_o) && $stable(total_length_o) && $stable(error_code_o))
    else $error("result changed while stalled");

  // segment numbers are one-based
  a_index_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> segment_index_o != 8'd0)
    else $error("segment index zero");

  // a clean descriptor carries header plus body length
  a_len_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && error_code_o == ERR_NONE |->
      load_end_o >= load_start_o &&
      total_length_o == 17'(load_end_o) - 17'(load_start_o) + 17'd1 +
        (marker_seen_o ? 17'd6 : 17'd4))
    else $error("total length mismatch");

  // reversed addresses give no length
  a_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && error_code_o == ERR_ORDER |->
      load_end_o < load_start_o && total_length_o == 17'd0)
    else $error("end below start descriptor malformed");

  // running out of numbers leaves the address fields clear
  a_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && error_code_o == ERR_COUNT |->
      load_start_o == 16'd0 && load_end_o == 16'd0 && total_length_o == 17'd0 &&
      !marker_seen_o)
    else $error("segment limit descriptor malformed");

endmodule

bind binary_load_segment_parser_core blsp_checker u_blsp_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .out_valid_o     (out_valid_o),
  .out_ready_i     (out_ready_i),
  .segment_index_o (segment_index_o),
  .header_offset_o (header_offset_o),
  .load_start_o    (load_start_o),
  .load_end_o      (load_end_o),
  .total_length_o  (total_length_o),
  .marker_seen_o   (marker_seen_o),
  .error_code_o    (error_code_o)
);

`default_nettype wire

// ----- tb/sv/binary_load_segment_parser_core_test.sv -----
// testbench for the segment parser core: byte stream in, segment descriptors out
`timescale 1ns / 100ps

module binary_load_segment_parser_core_test;
  import blsp_pkg::*;

  localparam int HOLD_CYCLES = 200;
  localparam int PHASE_BYTES = 533;
  localparam int IGNORED_BYTES = 20;
  localparam int DIR_ROWS = 25;
  localparam seg_desc_t NO_DESC = '0;

  // how the image stream is closed; one choice per run since reset is applied once
  typedef enum int {
    TAIL_OPEN,
    TAIL_CLEAN,
    TAIL_ORDER,
    TAIL_COUNT,
    TAIL_AT_END,
    TAIL_IN_HEAD,
    TAIL_IN_DATA
  } img_tail_e;

  // one row of the directed table
  typedef struct packed {
    logic [7:0] stream_byte;
    logic       final_byte;
    logic       typed;
    seg_desc_t  want;
  } dir_row_t;

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   in_valid_i = 1'b0;
  logic                   in_ready_o;
  logic [7:0]             stream_byte_i = 8'h00;
  logic                   final_byte_i = 1'b0;
  logic                   out_valid_o;
  logic                   out_ready_i = 1'b0;
  logic [7:0]             segment_index_o;
  logic [OFFSET_BITS-1:0] header_offset_o;
  logic [15:0]            load_start_o;
  logic [15:0]            load_end_o;
  logic [16:0]            total_length_o;
  logic                   marker_seen_o;
  logic [1:0]             error_code_o;

  binary_load_segment_parser_core dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .stream_byte_i  (stream_byte_i),
    .final_byte_i   (final_byte_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .segment_index_o(segment_index_o),
    .header_offset_o(header_offset_o),
    .load_start_o   (load_start_o),
    .load_end_o     (load_end_o),
    .total_length_o (total_length_o),
    .marker_seen_o  (marker_seen_o),
    .error_code_o   (error_code_o)
  );

  // parse state mirrored by the predictor
  phase_e                 parse_ph = PH_HEAD0;
  logic [OFFSET_BITS-1:0] byte_pos = '0;
  logic [OFFSET_BITS-1:0] head_pos = '0;
  logic [7:0]             low_byte = '0;
  logic [15:0]            start_addr = '0;
  logic [7:0]             end_low = '0;
  logic [16:0]            data_left = '0;
  logic [7:0]             seg_count = '0;
  logic                   has_marker = 1'b0;
  logic                   halted = 1'b0;

  seg_desc_t pending_desc [$];
  int        src_idle_pct = 20;
  int        sink_idle_pct = 56;
  logic      sink_block = 1'b0;
  bit        hold_req = 1'b0;
  int        bytes_sent = 0;
  int        descs_checked = 0;
  int        descs_flagged = 0;
  int        mismatches = 0;

  // clock
  initial begin
    forever #6 clk_i = ~clk_i;
  end

  // overall time limit
  initial begin
    #5_000_000;
    $display("Test completed with failures");
    $finish;
  end

  // receiver ready, random stalls plus the long hold-off
  always @(posedge clk_i) begin
    out_ready_i <= !sink_block && ($urandom_range(99) >= sink_idle_pct);
  end

  // long receiver hold-off, counted here so the sender keeps offering bytes
  initial begin
    wait (hold_req);
    sink_block <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk_i);
    sink_block <= 1'b0;
  end

  // one parse step on an accepted byte, at most one descriptor out
  task automatic parse_byte(input logic [7:0] b, input logic fin,
                            output bit got, output seg_desc_t d);
    logic [OFFSET_BITS-1:0] here;
    logic [15:0]            endv;
    got = 1'b0;
    d = NO_DESC;
    if (halted) return;
    here = byte_pos;
    byte_pos = byte_pos + 1'b1;
    case (parse_ph)
      PH_HEAD0: begin
        // no segment numbers left
        if (seg_count >= MAX_SEGMENTS) begin
          got = 1'b1;
          d.segment_index = seg_count;
          d.header_offset = here;
          d.error_code = ERR_COUNT;
          halted = 1'b1;
          return;
        end
        head_pos = here;
        low_byte = b;
        has_marker = 1'b0;
        start_addr = '0;
        parse_ph = PH_HEAD1;
      end
      PH_HEAD1: begin
        if (low_byte == MARKER_BYTE && b == MARKER_BYTE) begin
          has_marker = 1'b1;
          parse_ph = PH_STLO;
        end else begin
          start_addr = {b, low_byte};
          parse_ph = PH_ENDLO;
        end
      end
      PH_STLO: begin
        low_byte = b;
        parse_ph = PH_STHI;
      end
      PH_STHI: begin
        start_addr = {b, low_byte};
        parse_ph = PH_ENDLO;
      end
      PH_ENDLO: begin
        end_low = b;
        parse_ph = PH_ENDHI;
      end
      PH_ENDHI: begin
        // header complete, descriptor goes out
        endv = {b, end_low};
        seg_count = seg_count + 1'b1;
        got = 1'b1;
        d.segment_index = seg_count;
        d.header_offset = head_pos;
        d.load_start = start_addr;
        d.load_end = endv;
        d.marker_seen = has_marker;
        if (endv < start_addr) begin
          d.error_code = ERR_ORDER;
          halted = 1'b1;
          return;
        end
        data_left = {1'b0, endv} - {1'b0, start_addr} + 17'd1;
        if (has_marker) d.total_length = data_left + {14'd0, HDR_LEN_MARK};
        else d.total_length = data_left + {14'd0, HDR_LEN_BARE};
        if (fin) d.error_code = ERR_TRUNC;
        else d.error_code = ERR_NONE;
        parse_ph = PH_DATA;
        if (fin) halted = 1'b1;
        return;
      end
      default: begin
        if (data_left != 0) data_left = data_left - 1'b1;
        if (data_left == 0) begin
          parse_ph = PH_HEAD0;
        end else if (fin) begin
          // image stops inside the data
          got = 1'b1;
          d.segment_index = seg_count;
          d.header_offset = head_pos;
          d.load_start = start_addr;
          d.marker_seen = has_marker;
          d.error_code = ERR_TRUNC;
          halted = 1'b1;
          return;
        end
      end
    endcase
    if (fin) begin
      // image stops inside a header
      if (parse_ph != PH_HEAD0 && parse_ph != PH_DATA) begin
        got = 1'b1;
        d.segment_index = seg_count + 1'b1;
        d.header_offset = head_pos;
        if (parse_ph == PH_ENDLO || parse_ph == PH_ENDHI) d.load_start = start_addr;
        d.marker_seen = has_marker;
        d.error_code = ERR_TRUNC;
      end
      halted = 1'b1;
    end
  endtask

  function automatic seg_desc_t ok_desc(input int idx, input int hoff, input int st,
                                        input int en, input int len, input bit mk);
    seg_desc_t d;
    d = NO_DESC;
    d.segment_index = 8'(idx);
    d.header_offset = OFFSET_BITS'(hoff);
    d.load_start = 16'(st);
    d.load_end = 16'(en);
    d.total_length = 17'(len);
    d.marker_seen = mk;
    d.error_code = ERR_NONE;
    return d;
  endfunction

  // offer one byte, wait for its transfer, then log what it should produce
  task automatic send_byte(input logic [7:0] b, input logic fin,
                           input bit typed, input seg_desc_t want);
    bit        got;
    seg_desc_t d;
    if ($urandom_range(99) < src_idle_pct) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < src_idle_pct);
    end
    in_valid_i <= 1'b1;
    stream_byte_i <= b;
    final_byte_i <= fin;
    do @(posedge clk_i); while (!in_ready_o);
    bytes_sent++;
    parse_byte(b, fin, got, d);
    if (typed) pending_desc.push_back(want);
    else if (got) pending_desc.push_back(d);
  endtask

  // build one well-formed segment, or one that closes the image, cleanly or broken
  task automatic send_segment(input img_tail_e tail, input bit short_only);
    logic [7:0] img [$];
    int         len;
    int         s;
    int         e;
    int         r;
    int         hdr;
    int         fin_at;
    int         stop;
    bit         mark;
    case ($urandom_range(7))
      0: s = 0;
      1: s = 65535;
      2: s = ($urandom_range(255) << 8) | 255;
      default: s = $urandom_range(65535);
    endcase
    r = $urandom_range(99);
    if (short_only) len = $urandom_range(2, 1);
    else if (r < 75) len = $urandom_range(4, 1);
    else if (r < 97) len = $urandom_range(24, 5);
    else len = $urandom_range(200, 25);
    if (tail == TAIL_IN_DATA && len < 2) len = 2;
    if (tail == TAIL_ORDER) begin
      if (s == 0) s = $urandom_range(65535, 1);
      e = $urandom_range(s - 1);
    end else begin
      if (s + len - 1 > 65535) s = 65536 - len;
      e = s + len - 1;
    end
    // a bare start of FFFF would read as a marker
    mark = $urandom_range(1);
    if (!mark && s == 65535) mark = 1'b1;
    if (mark) begin
      img.push_back(MARKER_BYTE);
      img.push_back(MARKER_BYTE);
    end
    img.push_back(8'(s));
    img.push_back(8'(s >> 8));
    img.push_back(8'(e));
    img.push_back(8'(e >> 8));
    hdr = img.size();
    if (tail == TAIL_OPEN || tail == TAIL_CLEAN || tail == TAIL_IN_DATA) begin
      for (int i = 0; i < len; i++) begin
        if ($urandom_range(7) == 0) img.push_back(MARKER_BYTE);
        else img.push_back(8'($urandom_range(255)));
      end
    end
    fin_at = -1;
    case (tail)
      TAIL_CLEAN:   fin_at = img.size() - 1;
      TAIL_AT_END:  fin_at = hdr - 1;
      TAIL_IN_HEAD: fin_at = $urandom_range(hdr - 2);
      TAIL_IN_DATA: fin_at = hdr + $urandom_range(len - 2);
      default: ;
    endcase
    stop = (fin_at < 0) ? img.size() : fin_at + 1;
    for (int i = 0; i < stop; i++) send_byte(img[i], i == fin_at, 1'b0, NO_DESC);
  endtask

  // stop offering and wait for every logged descriptor
  task automatic await_descriptors();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending_desc.size() != 0);
  endtask

  // result side: each descriptor transfer against the oldest logged one
  always @(posedge clk_i) begin
    seg_desc_t want;
    seg_desc_t seen;
    if (rst_ni && out_valid_o && out_ready_i) begin
      seen.segment_index = segment_index_o;
      seen.header_offset = header_offset_o;
      seen.load_start = load_start_o;
      seen.load_end = load_end_o;
      seen.total_length = total_length_o;
      seen.marker_seen = marker_seen_o;
      seen.error_code = err_e'(error_code_o);
      descs_checked++;
      if (seen.error_code != ERR_NONE) descs_flagged++;
      if (pending_desc.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected descriptor: idx %0d hoff %0d err %0d",
                   seen.segment_index, seen.header_offset, seen.error_code);
      end else begin
        want = pending_desc.pop_front();
        if (seen.segment_index != want.segment_index ||
            seen.header_offset != want.header_offset ||
            seen.load_start != want.load_start ||
            seen.load_end != want.load_end ||
            seen.total_length != want.total_length ||
            seen.marker_seen != want.marker_seen ||
            seen.error_code != want.error_code) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("descriptor %0d mismatch", descs_checked);
            $display("  want idx %0d hoff %0d start %h end %h len %0d mark %0d err %0d",
                     want.segment_index, want.header_offset, want.load_start,
                     want.load_end, want.total_length, want.marker_seen, want.error_code);
            $display("  got  idx %0d hoff %0d start %h end %h len %0d mark %0d err %0d",
                     seen.segment_index, seen.header_offset, seen.load_start,
                     seen.load_end, seen.total_length, seen.marker_seen, seen.error_code);
          end
        end
      end
    end
  end

  // stimulus
  initial begin
    dir_row_t  dir_table [DIR_ROWS];
    img_tail_e tail;
    int        phase_start;
    // marker and zero addresses, bare xxFF start, all-ones addresses,
    // then FF FF inside data where it is plain content
    dir_table = '{
      '{8'hFF, 1'b0, 1'b0, NO_DESC},
      '{8'hFF, 1'b0, 1'b0, NO_DESC},
      '{8'h00, 1'b0, 1'b0, NO_DESC},
      '{8'h00, 1'b0, 1'b0, NO_DESC},
      '{8'h00, 1'b0, 1'b0, NO_DESC},
      '{8'h00, 1'b0, 1'b1, ok_desc(1, 0, 16'h0000, 16'h0000, 7, 1'b1)},
      '{8'h5A, 1'b0, 1'b0, NO_DESC},
      '{8'hFF, 1'b0, 1'b0, NO_DESC},
      '{8'h12, 1'b0, 1'b0, NO_DESC},
      '{8'hFF, 1'b0, 1'b0, NO_DESC},
      '{8'h12, 1'b0, 1'b0, NO_DESC},
      '{8'hFF, 1'b0, 1'b0, NO_DESC},
      '{8'hFF, 1'b0, 1'b0, NO_DESC},
      '{8'hFF, 1'b0, 1'b0, NO_DESC},
      '{8'hFF, 1'b0, 1'b0, NO_DESC},
      '{8'hFF, 1'b0, 1'b0, NO_DESC},
      '{8'hFF, 1'b0, 1'b0, NO_DESC},
      '{8'hFF, 1'b0, 1'b1, ok_desc(3, 12, 16'hFFFF, 16'hFFFF, 7, 1'b1)},
      '{8'h00, 1'b0, 1'b0, NO_DESC},
      '{8'h00, 1'b0, 1'b0, NO_DESC},
      '{8'h00, 1'b0, 1'b0, NO_DESC},
      '{8'h01, 1'b0, 1'b0, NO_DESC},
      '{8'h00, 1'b0, 1'b0, NO_DESC},
      '{8'hFF, 1'b0, 1'b0, NO_DESC},
      '{8'hFF, 1'b0, 1'b0, NO_DESC}
    };

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed segments
    foreach (dir_table[i])
      send_byte(dir_table[i].stream_byte, dir_table[i].final_byte,
                dir_table[i].typed, dir_table[i].want);

    // random segments under three idle patterns
    for (int ph = 0; ph < 3; ph++) begin
      src_idle_pct = (ph == 0) ? 20 : (ph == 1) ? 56 : 0;
      sink_idle_pct = (ph == 0) ? 56 : (ph == 1) ? 20 : 0;
      if (ph == 1) await_descriptors();
      phase_start = bytes_sent;
      while (bytes_sent - phase_start < PHASE_BYTES && seg_count < MAX_SEGMENTS - 1) begin
        if (ph == 0 && !hold_req && bytes_sent - phase_start > 150) hold_req = 1'b1;
        send_segment(TAIL_OPEN, 1'b0);
      end
    end

    // close the image one way, then bytes the halted block must drop
    tail = img_tail_e'($urandom_range(int'(TAIL_IN_DATA), int'(TAIL_CLEAN)));
    if (tail == TAIL_COUNT) begin
      while (seg_count < MAX_SEGMENTS) send_segment(TAIL_OPEN, 1'b1);
      send_byte(8'($urandom_range(255)), 1'($urandom_range(1)), 1'b0, NO_DESC);
    end else begin
      send_segment(tail, 1'b0);
    end
    repeat (IGNORED_BYTES)
      send_byte(8'($urandom_range(255)), 1'($urandom_range(1)), 1'b0, NO_DESC);

    await_descriptors();
    repeat (8) @(posedge clk_i);
    mismatches += pending_desc.size();

    $display("streamed %0d bytes over %0d segments, %0d descriptors checked (%0d flagged)",
             bytes_sent, seg_count, descs_checked, descs_flagged);
    $display("image closed by %s, then %0d dropped bytes", tail.name(), IGNORED_BYTES);
    if (mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
hw/rtl/blsp_pkg.sv
hw/rtl/blsp_in_reg.sv
hw/rtl/blsp_parser.sv
hw/rtl/blsp_out_reg.sv
hw/rtl/binary_load_segment_parser_core.sv
hw/rtl/blsp_checker.sv
tb/sv/binary_load_segment_parser_core_test.sv
